@@ src/rsa_block_cipher_macros.svh @@
// Assertion macros used by the checker file.
`ifndef RSA_BLOCK_CIPHER_MACROS_SVH
`define RSA_BLOCK_CIPHER_MACROS_SVH
// Implication checked on every clock edge outside reset.
`define RSA_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// Implication whose consequent is checked in the following cycle.
`define RSA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`endif

@@ src/rsa_pkg.sv @@
// Shared types and constants of the RSA engine.
package rsa_pkg;
  localparam int MODULUS_BITS_DEF = 31;
  localparam int MAX_CPB_DEF = 3;
  localparam int CHAR_BITS = 7;
  localparam int CFG_BITS = 31;
  localparam int CFG_IDX_BITS = 2;

  localparam logic [CFG_IDX_BITS-1:0] REG_MODE = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_CPB = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_EXP = 2'd2;
  localparam logic [CFG_IDX_BITS-1:0] REG_MOD = 2'd3;

  typedef enum logic [3:0] {
    ST_IDLE, ST_REDUCE, ST_EXP_CHECK, ST_MUL_RES, ST_WAIT_RES,
    ST_MUL_SQR, ST_WAIT_SQR, ST_EMIT, ST_EMIT_WAIT
  } state_t;

  // Controller to datapath.
  typedef struct packed {
    logic load;        // capture base and exponent
    logic red_start;   // begin base reduction
    logic mul_start;   // begin a modular multiply
    logic mul_sel_res; // multiply result (1) or square base (0)
    logic exp_shift;   // drop one exponent bit
    logic emit_load;   // load output register
    logic emit_shift;  // next decrypt character
  } ctl_t;

  // Datapath to controller.
  typedef struct packed {
    logic busy;
    logic exp_zero;
    logic exp_lsb;
  } sts_t;
endpackage

@@ src/rsa_datapath.sv @@
// Modular multiply/reduce unit with exponent, base and result registers.
module rsa_datapath #(
  parameter int MODULUS_BITS = rsa_pkg::MODULUS_BITS_DEF
) (
  input  logic                    clk,
  input  logic                    rst,
  input  rsa_pkg::ctl_t           ctl,
  output rsa_pkg::sts_t           sts,
  input  logic [MODULUS_BITS-1:0] base_in,
  input  logic [30:0]             exp_in,
  input  logic [MODULUS_BITS-1:0] mod_in,
  output logic [MODULUS_BITS-1:0] result
);
  import rsa_pkg::*;
  localparam int CW = $clog2(MODULUS_BITS + 1);
  localparam int W = MODULUS_BITS;

  logic [W-1:0] res, b, a_op, b_op, r;
  logic [30:0]  e;
  logic [CW-1:0] cnt;
  logic busy, reducing;
  logic [W:0] r2, r2s, r3, r3s;
  logic bit_now;

  // One bit of the shift-and-add multiply per cycle. Reduction of the base
  // reuses the same loop as base * 1.
  always_comb begin
    bit_now = b_op[cnt[CW-1:0] - CW'(1)];
    r2  = {r, 1'b0};
    r2s = (r2 >= {1'b0, mod_in}) ? r2 - {1'b0, mod_in} : r2;
    r3  = bit_now ? r2s + {1'b0, a_op} : r2s;
    r3s = (r3 >= {1'b0, mod_in}) ? r3 - {1'b0, mod_in} : r3;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      reducing <= 1'b0;
      cnt <= '0;
    end else begin
      if (ctl.load) begin
        e <= exp_in;
        b <= base_in;
        res <= W'(1);
      end
      if (ctl.exp_shift) e <= e >> 1;
      if (ctl.red_start) begin
        // base mod m: a*1 via Horner over base bits (base*1 with a = 1 bits)
        a_op <= W'(1);
        b_op <= b;
        r <= '0;
        cnt <= CW'(W);
        busy <= 1'b1;
        reducing <= 1'b1;
      end else if (ctl.mul_start) begin
        a_op <= ctl.mul_sel_res ? res : b;
        b_op <= b;
        r <= '0;
        cnt <= CW'(W);
        busy <= 1'b1;
        reducing <= 1'b0;
      end else if (busy) begin
        r <= r3s[W-1:0];
        cnt <= cnt - CW'(1);
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          if (reducing) b <= r3s[W-1:0];
          else if (a_op == res && ctl.mul_sel_res) res <= r3s[W-1:0];
          else b <= r3s[W-1:0];
        end
      end
    end
  end

  assign sts.busy = busy;
  assign sts.exp_zero = (e == '0);
  assign sts.exp_lsb = e[0];
  assign result = res;
endmodule

@@ src/rsa_ctrl.sv @@
// Controller state machine: input acceptance, exponent sequencing and result delivery.
module rsa_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_fire,
  input  logic           need_exp,
  input  logic           emit_more,
  input  logic           out_fire,
  input  rsa_pkg::sts_t  sts,
  output rsa_pkg::ctl_t  ctl,
  output logic           in_ready,
  output logic           out_valid
);
  import rsa_pkg::*;
  state_t state, state_next;
  logic sel_res;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      sel_res <= 1'b0;
    end else begin
      state <= state_next;
      if (ctl.mul_start) sel_res <= ctl.mul_sel_res;
    end
  end

  always_comb begin
    state_next = state;
    ctl = '0;
    ctl.mul_sel_res = sel_res;
    in_ready = 1'b0;
    out_valid = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_fire && need_exp) begin
          ctl.load = 1'b1;
          state_next = ST_REDUCE;
        end
      end
      ST_REDUCE: begin
        ctl.red_start = 1'b1;
        state_next = ST_WAIT_SQR;
      end
      ST_EXP_CHECK: begin
        if (sts.exp_zero) begin
          ctl.emit_load = 1'b1;
          state_next = ST_EMIT;
        end else if (sts.exp_lsb) state_next = ST_MUL_RES;
        else state_next = ST_MUL_SQR;
      end
      ST_MUL_RES: begin
        ctl.mul_start = 1'b1;
        ctl.mul_sel_res = 1'b1;
        state_next = ST_WAIT_RES;
      end
      ST_WAIT_RES: if (!sts.busy) state_next = ST_MUL_SQR;
      ST_MUL_SQR: begin
        ctl.mul_start = 1'b1;
        ctl.mul_sel_res = 1'b0;
        ctl.exp_shift = 1'b1;
        state_next = ST_WAIT_SQR;
      end
      ST_WAIT_SQR: if (!sts.busy) state_next = ST_EXP_CHECK;
      ST_EMIT: begin
        out_valid = 1'b1;
        if (out_fire) begin
          if (emit_more) ctl.emit_shift = 1'b1;
          else state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end
endmodule

@@ src/rsa_block_cipher.sv @@
// Top level of the RSA square-and-multiply engine.
// Computes base^exponent mod modulus one item at a time. In encrypt mode
// (mode 0) 7-bit characters are packed lowest first into blocks of
// chars_per_block; a full block, or a partial block closed by last_in (zero
// padded), is exponentiated and delivered as one transfer with last copied
// from last_in. A character that does not close a block is taken with no
// output. In decrypt mode each word is exponentiated and delivered as
// chars_per_block characters, the final one marked by last. The base
// reduction and every modular multiply run through one shared shift-and-add
// unit, and each exponent bit passes through a check state. Decrypt
// characters follow one per transfer, and a new input is taken the cycle
// after the last result transfer. Exponent zero yields 1. The user must write
// configuration only while idle; the block itself does not enforce it.
module rsa_block_cipher #(
  parameter int MODULUS_BITS = rsa_pkg::MODULUS_BITS_DEF,
  parameter int MAX_CHARS_PER_BLOCK = rsa_pkg::MAX_CPB_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       s_tvalid,
  output logic                       s_tready,
  // [MODULUS_BITS-1:0] data_in, upper bits zero
  input  logic [((MODULUS_BITS + 7) / 8) * 8 - 1:0] s_tdata,
  input  logic                       s_tlast,   // last_in
  output logic                       m_tvalid,
  input  logic                       m_tready,
  // [MODULUS_BITS-1:0] data_out, upper bits zero
  output logic [((MODULUS_BITS + 7) / 8) * 8 - 1:0] m_tdata,
  output logic                       m_tlast,   // last_out
  input  logic                       cfg_we,
  input  logic [rsa_pkg::CFG_IDX_BITS-1:0] cfg_index,
  input  logic [rsa_pkg::CFG_BITS-1:0]     cfg_data
);
  import rsa_pkg::*;
  localparam int TDATA_W = ((MODULUS_BITS + 7) / 8) * 8;
  localparam int ACC_W = CHAR_BITS * MAX_CHARS_PER_BLOCK;
  localparam int PCW = $clog2(MAX_CHARS_PER_BLOCK + 1);
  localparam int POSW = (MAX_CHARS_PER_BLOCK > 1) ? $clog2(MAX_CHARS_PER_BLOCK) : 1;

  logic                    mode;
  logic [1:0]              cpb;
  logic [30:0]             exponent;
  logic [MODULUS_BITS-1:0] modulus;
  logic [ACC_W-1:0]        pack_acc, acc_now;
  logic [PCW-1:0]          pack_count, blk, pos;
  logic                    in_fire, out_fire, need_exp, emit_more, last_hold;
  logic [MODULUS_BITS-1:0] base, mod_eff, result, out_word;
  logic [PCW-1:0]          emit_idx;
  ctl_t ctl;
  sts_t sts;

  // Hold configuration.
  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= 1'b0;
      cpb <= 2'd1;
      exponent <= 31'd1;
      modulus <= MODULUS_BITS'(2);
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_MODE: mode <= cfg_data[0];
        REG_CPB:  cpb <= cfg_data[1:0];
        REG_EXP:  exponent <= cfg_data[30:0];
        REG_MOD:  modulus <= MODULUS_BITS'(cfg_data);
        default: ;
      endcase
    end
  end

  always_comb begin
    blk = (cpb == 2'd0) ? PCW'(1) : PCW'(cpb);
    if (blk > PCW'(MAX_CHARS_PER_BLOCK)) blk = PCW'(MAX_CHARS_PER_BLOCK);
    mod_eff = (modulus < MODULUS_BITS'(2)) ? MODULUS_BITS'(2) : modulus;
    pos = (pack_count >= PCW'(MAX_CHARS_PER_BLOCK)) ?
          PCW'(MAX_CHARS_PER_BLOCK - 1) : pack_count;
    acc_now = pack_acc | (ACC_W'(s_tdata[CHAR_BITS-1:0]) << (CHAR_BITS * pos));
    need_exp = mode || (pos + PCW'(1) >= blk) || s_tlast;
    base = mode ? s_tdata[MODULUS_BITS-1:0] : MODULUS_BITS'(acc_now);
  end

  assign in_fire = s_tvalid && s_tready;
  assign out_fire = m_tvalid && m_tready;
  assign emit_more = mode && (emit_idx + PCW'(1) < blk);

  // Advance the packing state on accepted encrypt characters.
  always_ff @(posedge clk) begin
    if (rst) begin
      pack_acc <= '0;
      pack_count <= '0;
    end else if (in_fire && !mode) begin
      if (need_exp) begin
        pack_acc <= '0;
        pack_count <= '0;
      end else begin
        pack_acc <= acc_now;
        pack_count <= pos + PCW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) emit_idx <= '0;
    else if (in_fire) begin
      last_hold <= s_tlast;
      emit_idx <= '0;
    end else if (ctl.emit_shift) emit_idx <= emit_idx + PCW'(1);
    if (ctl.emit_load) out_word <= result;
    else if (ctl.emit_shift) out_word <= out_word >> CHAR_BITS;
  end

  assign m_tdata = TDATA_W'(mode ? MODULUS_BITS'(out_word[CHAR_BITS-1:0]) : out_word);
  assign m_tlast = mode ? !emit_more : last_hold;

  rsa_ctrl u_ctrl (
    .clk, .rst, .in_fire, .need_exp, .emit_more, .out_fire, .sts, .ctl,
    .in_ready(s_tready), .out_valid(m_tvalid)
  );

  rsa_datapath #(.MODULUS_BITS(MODULUS_BITS)) u_dp (
    .clk, .rst, .ctl, .sts, .base_in(base), .exp_in(exponent), .mod_in(mod_eff),
    .result
  );
endmodule

@@ src/rsa_checker.sv @@
// Port-level checker for the RSA engine, bound to the top level.
`include "rsa_block_cipher_macros.svh"
module rsa_checker #(
  parameter int MODULUS_BITS = rsa_pkg::MODULUS_BITS_DEF
) (
  input logic clk,
  input logic rst,
  input logic s_tvalid,
  input logic s_tready,
  input logic m_tvalid,
  input logic m_tready,
  input logic [((MODULUS_BITS + 7) / 8) * 8 - 1:0] m_tdata
);
  `RSA_ASSERT_IMP(a_no_in_while_out, m_tvalid, !s_tready, "input taken while output pending")
  `RSA_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "stalled output changed")
  `RSA_ASSERT_NEXT(a_reset_idle, $fell(rst), !m_tvalid, "output valid right after reset")
endmodule

bind rsa_block_cipher rsa_checker #(.MODULUS_BITS(MODULUS_BITS)) u_rsa_checker (
  .clk, .rst, .s_tvalid, .s_tready, .m_tvalid, .m_tready, .m_tdata
);

@@ tb/tb_top.sv @@
// Self-checking testbench for the RSA block cipher engine.
`timescale 1ns / 100ps

module tb_top;
  import rsa_pkg::*;

  localparam int W = MODULUS_BITS_DEF;
  localparam int TD = ((W + 7) / 8) * 8;
  localparam longint unsigned WMASK = (64'd1 << W) - 1;
  localparam int IDLE_LIMIT = 200000;

  typedef struct {
    logic [W-1:0] data;
    logic         last;
  } word_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [TD-1:0] s_tdata = '0;
  logic s_tlast = 1'b0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [TD-1:0] m_tdata;
  logic m_tlast;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_BITS-1:0] cfg_index = REG_MODE;
  logic [CFG_BITS-1:0] cfg_data = '0;

  rsa_block_cipher u_top (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // Shadow copy of the configuration and packing state
  logic                  sh_mode;
  logic [1:0]            sh_cpb;
  logic [W-1:0]          sh_exp;
  logic [W-1:0]          sh_mod;
  longint unsigned       pack_acc;
  int                    pack_cnt;

  word_t send_q[$];      // items waiting to be offered
  word_t cipher_q[$];    // results still owed by the engine
  int    errors = 0;
  int    send_gap = 0;
  int    recv_gap = 0;
  int    hold_cnt = 0;
  int    hold_req = 0;   // bumped to ask the receiver for a long hold-off
  int    hold_seen = 0;
  int    idle_cycles = 0;
  bit    quiet = 0;      // when set, no idling on either side

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic int pick_gap();
    if (quiet) return 0;
    if ($urandom_range(0, 19) == 0) return $urandom_range(20, 120);
    if ($urandom_range(0, 2) == 0) return $urandom_range(1, 3);
    return 0;
  endfunction

  // (a * b) mod m by shift and add, one bit of b per step
  function automatic longint unsigned mul_mod(longint unsigned a, longint unsigned b,
                                              longint unsigned m);
    longint unsigned r;
    r = 0;
    for (int i = W - 1; i >= 0; i--) begin
      r = r << 1;
      if (r >= m) r -= m;
      if (b[i]) begin
        r += a;
        if (r >= m) r -= m;
      end
    end
    return r;
  endfunction

  function automatic longint unsigned pow_mod(longint unsigned base, longint unsigned e,
                                              longint unsigned m);
    longint unsigned res;
    longint unsigned b;
    res = 1;
    b = base % m;
    while (e != 0) begin
      if (e[0]) res = mul_mod(res, b, m);
      e = e >> 1;
      b = mul_mod(b, b, m);
    end
    return res;
  endfunction

  // Work out the results one accepted transfer owes and queue them
  function automatic void predict_cipher(logic [W-1:0] data, logic last);
    int n;
    longint unsigned m;
    longint unsigned x;
    int pos;
    word_t r;
    n = (sh_cpb == 0) ? 1 : (sh_cpb > MAX_CPB_DEF ? MAX_CPB_DEF : int'(sh_cpb));
    m = (sh_mod < 2) ? 2 : longint'(sh_mod);
    if (sh_mode == 1'b0) begin
      pos = (pack_cnt >= MAX_CPB_DEF) ? MAX_CPB_DEF - 1 : pack_cnt;
      pack_acc |= longint'(data[CHAR_BITS-1:0]) << (CHAR_BITS * pos);
      pack_cnt = pos + 1;
      if (pack_cnt >= n || last) begin
        r.data = W'(pow_mod(pack_acc, sh_exp, m) & WMASK);
        r.last = last;
        cipher_q.push_back(r);
        pack_acc = 0;
        pack_cnt = 0;
      end
    end else begin
      x = pow_mod(data, sh_exp, m);
      for (int j = 0; j < n; j++) begin
        r.data = W'((x >> (CHAR_BITS * j)) & 127);
        r.last = (j + 1 == n);
        cipher_q.push_back(r);
      end
    end
  endfunction

  // Driver: offer queued items, predict on each accepted transfer
  always @(posedge clk) begin
    word_t it;
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) predict_cipher(s_tdata[W-1:0], s_tlast);
      if (!s_tvalid || s_tready) begin
        if (send_gap > 0) begin
          send_gap--;
          s_tvalid <= 1'b0;
        end else if (send_q.size() > 0) begin
          it = send_q.pop_front();
          s_tvalid <= 1'b1;
          s_tdata <= TD'(it.data);
          s_tlast <= it.last;
          send_gap = pick_gap();
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // Monitor: check each result transfer against the oldest expectation
  always @(posedge clk) begin
    word_t e;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (cipher_q.size() == 0) begin
          $display("%0t: unexpected result data=%h last=%b", $time, m_tdata, m_tlast);
          errors++;
        end else begin
          e = cipher_q.pop_front();
          if (m_tdata !== TD'(e.data)) begin
            $display("%0t: data mismatch expected %h actual %h", $time, e.data, m_tdata);
            errors++;
          end
          if (m_tlast !== e.last) begin
            $display("%0t: last mismatch expected %b actual %b", $time, e.last, m_tlast);
            errors++;
          end
        end
      end
      // Long hold-off on request, otherwise random stalls
      if (hold_seen != hold_req) begin
        hold_seen = hold_req;
        hold_cnt = 6000;
      end
      if (hold_cnt > 0) begin
        hold_cnt--;
        m_tready <= 1'b0;
      end else if (recv_gap > 0) begin
        recv_gap--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
        recv_gap = pick_gap();
      end
    end
  end

  // Watchdog: end the run when nothing moves for too long
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || rst) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("FAIL");
        $finish;
      end
    end
  end

  task automatic write_reg(logic [CFG_IDX_BITS-1:0] idx, logic [CFG_BITS-1:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    case (idx)
      REG_MODE: sh_mode = val[0];
      REG_CPB:  sh_cpb = val[1:0];
      REG_EXP:  sh_exp = val;
      REG_MOD:  sh_mod = val;
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_all(logic md, logic [1:0] cpb, logic [W-1:0] ex, logic [W-1:0] mo);
    write_reg(REG_MODE, md);
    write_reg(REG_CPB, cpb);
    write_reg(REG_EXP, ex);
    write_reg(REG_MOD, mo);
  endtask

  // Hold until the engine owes nothing, then let a non-closing character settle
  task automatic drain();
    while (send_q.size() > 0 || s_tvalid || cipher_q.size() > 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic push(logic [W-1:0] d, logic l);
    word_t it;
    it.data = d;
    it.last = l;
    send_q.push_back(it);
  endtask

  initial begin
    int len;
    logic md;
    sh_mode = 1'b0;
    sh_cpb = 2'd1;
    sh_exp = 1;
    sh_mod = 2;
    pack_acc = 0;
    pack_cnt = 0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Reset configuration: exponent 1 mod 2 on single characters
    push(7'h7f, 1'b0);
    push(7'h00, 1'b1);
    drain();

    // Packing extremes: upper bits ignored, partial block closed by last
    set_all(1'b0, 2'd3, 31'd65537, 31'h7fffffff);
    push(31'h7fffffff, 1'b0);
    push(31'h7fffff80, 1'b0);
    push(31'h0000007f, 1'b0);
    push(31'h00000041, 1'b1);
    push(31'h00000042, 1'b0);
    push(31'h00000043, 1'b0);
    push(31'h00000044, 1'b1);
    drain();

    // Exponent zero yields one; base reduced below a small modulus
    set_all(1'b0, 2'd2, 31'd0, 31'd3);
    push(7'h7f, 1'b0);
    push(7'h05, 1'b1);
    drain();

    // Decrypt: zero, maximum and a base above the modulus
    set_all(1'b1, 2'd3, 31'h7fffffff, 31'h7fffffff);
    push(31'd0, 1'b1);
    push(31'h7fffffff, 1'b0);
    push(31'h7ffffffe, 1'b0);
    drain();
    write_reg(REG_MOD, 31'd1000003);
    push(31'h7fffffff, 1'b0);
    drain();

    // Block size zero and modulus below two are clamped
    set_all(1'b1, 2'd0, 31'd5, 31'd1);
    push(31'd12345, 1'b0);
    drain();

    // Mode change mid-block keeps the packed characters
    set_all(1'b0, 2'd3, 31'd3, 31'd999983);
    push(7'h11, 1'b0);
    drain();
    write_reg(REG_MODE, 1'b1);
    push(31'd77, 1'b1);
    drain();
    set_all(1'b0, 2'd2, 31'd3, 31'd999983);
    push(7'h22, 1'b0);
    drain();

    // Long receiver hold-off with a fast exponent so the engine backs up
    set_all(1'b1, 2'd3, 31'd3, 31'h7fffffff);
    hold_req++;
    for (int i = 0; i < 12; i++) push(W'($urandom), 1'b0);
    drain();

    // Random phases of well-formed messages, occasional noise
    for (int ph = 0; ph < 8; ph++) begin
      md = $urandom_range(0, 1);
      quiet = ($urandom_range(0, 3) == 0);
      set_all(md, 2'($urandom_range(1, 3)),
              ($urandom_range(0, 5) == 0) ? W'($urandom) : W'($urandom_range(0, 300)),
              ($urandom_range(0, 5) == 0) ? 31'h7fffffff : W'($urandom_range(2, 31'h7fffffff)));
      for (int k = 0; k < 12; ) begin
        len = $urandom_range(1, 5);
        for (int c = 0; c < len; c++) begin
          push(W'($urandom), (c == len - 1) ? 1'b1 : ($urandom_range(0, 9) == 0));
          k++;
        end
      end
      drain();
    end

    quiet = 0;
    repeat (100) @(posedge clk);
    if (errors == 0 && cipher_q.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
